/* design/memory_snapshot_compare_filter_top_macros.svh */
`ifndef MEMORY_SNAPSHOT_COMPARE_FILTER_TOP_MACROS_SVH
`define MEMORY_SNAPSHOT_COMPARE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MSCF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MSCF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mscf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mscf_pkg;

  localparam int unsigned REGION_DEPTH_DEF = 131072;

  localparam int unsigned ADDR_IN_W   = 17;
  localparam int unsigned LIVE_W      = 32;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned SIZE_W      = 2;
  localparam int unsigned REGION_W    = 18;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 8;

  // actions
  localparam logic [ACTION_W-1:0] ACT_SNAPSHOT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CMP_SNAP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CMP_VALUE = 2'd2;

  // compare operators
  localparam logic [OP_W-1:0] CMP_LT = 3'd0;
  localparam logic [OP_W-1:0] CMP_GT = 3'd1;
  localparam logic [OP_W-1:0] CMP_LE = 3'd2;
  localparam logic [OP_W-1:0] CMP_GE = 3'd3;
  localparam logic [OP_W-1:0] CMP_EQ = 3'd4;
  localparam logic [OP_W-1:0] CMP_NE = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_SNAPSHOT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES    = 3'd5;

  localparam logic [REGION_W-1:0] REGION_BYTES_RST = 18'h20000;

  // one committed write into the store
  typedef struct packed {
    logic       cand_we;
    logic       cand_val;
    logic       snap_we;
    logic [7:0] snap_data;
  } store_wr_t;

endpackage

`default_nettype wire

/* design/mscf_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module mscf_store #(
  parameter int unsigned REGION_DEPTH = mscf_pkg::REGION_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [$clog2(REGION_DEPTH)-1:0]   rd_addr,
  output logic [31:0]                       rd_bytes,
  output logic                              rd_cand,
  input  mscf_pkg::store_wr_t               wr,
  input  logic [$clog2(REGION_DEPTH)-1:0]   wr_addr,
  output logic                              busy
);
  import mscf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(REGION_DEPTH);
  localparam int unsigned ROW_W  = ADDR_W - 2;
  localparam int unsigned ROWS   = (REGION_DEPTH + 3) / 4;

  // snapshot bytes, four banks interleaved on address[1:0]
  logic [7:0]       snap_mem [4][ROWS];
  logic [ROW_W-1:0] rd_rows  [4];
  logic [7:0]       rd_q     [4];
  logic [1:0]       rd_lo;

  logic             cand_mem [REGION_DEPTH];
  logic [ADDR_W-1:0] clr_idx;

  // bank b holds byte k of the word where (lo + k) mod 4 == b; it wraps to the next row
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_rows[b] = rd_addr[ADDR_W-1:2] + ROW_W'(2'(b) < rd_addr[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.snap_we) begin
      snap_mem[wr_addr[1:0]][wr_addr[ADDR_W-1:2]] <= wr.snap_data;
    end
    if (rd_en) begin
      for (int b = 0; b < 4; b++) begin
        rd_q[b] <= snap_mem[b][rd_rows[b]];
      end
      rd_lo <= rd_addr[1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_bytes[8*k +: 8] = rd_q[rd_lo + 2'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      cand_mem[clr_idx] <= 1'b0;
    end else if (wr.cand_we) begin
      cand_mem[wr_addr] <= wr.cand_val;
    end
    if (rd_en) begin
      rd_cand <= cand_mem[rd_addr];
    end
  end

  // clearing pass over the candidate bits after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + ADDR_W'(1);
      if (clr_idx == ADDR_W'(REGION_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/memory_snapshot_compare_filter_top.sv */
// A word accepted on s_axis runs through stages 1, 2 and 3; its result is registered onto m_axis.
// Throughput: one word per cycle outside the clearing pass; the whole pipe stalls only while the output waits.
// Each of three stages folds in the write committed at the edge before it.
// Reset is synchronous, active high; afterwards the candidate bits are cleared
// one per cycle, all REGION_DEPTH of them, with s_axis_tready low (config still taken).
`timescale 1ns / 1ps
`default_nettype none
`include "memory_snapshot_compare_filter_top_macros.svh"

module memory_snapshot_compare_filter_top #(
  parameter int unsigned REGION_DEPTH = mscf_pkg::REGION_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mscf_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mscf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [16:0] address, [48:17] live_bytes, [55:49] zero
  input  logic [mscf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] action
  input  logic [mscf_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] still_candidate, [7:1] zero
  output logic [mscf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import mscf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(REGION_DEPTH);
  localparam int unsigned EXT_W  = (ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W;
  localparam int unsigned LIM_W  = (ADDR_W + 1 > REGION_W) ? ADDR_W + 1 : REGION_W;
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(REGION_DEPTH);

  function automatic logic signed [32:0] ext_word(logic [31:0] w, logic [1:0] ds,
                                                  logic sgn);
    logic signed [32:0] r;
    case (ds)
      2'd0:    r = {{25{sgn & w[7]}}, w[7:0]};
      2'd1:    r = {{17{sgn & w[15]}}, w[15:0]};
      2'd2:    r = {{9{sgn & w[23]}}, w[23:0]};
      default: r = {sgn & w[31], w};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] fwd_bytes(logic [31:0] w, logic [ADDR_W-1:0] a,
                                            store_wr_t h, logic [ADDR_W-1:0] ha);
    logic [31:0] r;
    r = w;
    for (int k = 0; k < 4; k++) begin
      if (h.snap_we && ha == a + ADDR_W'(k)) begin
        r[8*k +: 8] = h.snap_data;
      end
    end
    return r;
  endfunction

  function automatic logic fwd_cand(logic c, logic [ADDR_W-1:0] a, store_wr_t h,
                                    logic [ADDR_W-1:0] ha);
    return (h.cand_we && ha == a) ? h.cand_val : c;
  endfunction

  // configuration
  logic [OP_W-1:0]     compare_op;
  logic [SIZE_W-1:0]   data_size;
  logic                signed_mode;
  logic                update_snapshot;
  logic [LIVE_W-1:0]   search_value;
  logic [REGION_W-1:0] region_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_op      <= CMP_EQ;
      data_size       <= '0;
      signed_mode     <= 1'b0;
      update_snapshot <= 1'b0;
      search_value    <= '0;
      region_bytes    <= REGION_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COMPARE_OP:      compare_op      <= cfg_wdata[OP_W-1:0];
        REG_DATA_SIZE:       data_size       <= cfg_wdata[SIZE_W-1:0];
        REG_SIGNED_MODE:     signed_mode     <= cfg_wdata[0];
        REG_UPDATE_SNAPSHOT: update_snapshot <= cfg_wdata[0];
        REG_SEARCH_VALUE:    search_value    <= cfg_wdata[LIVE_W-1:0];
        REG_REGION_BYTES:    region_bytes    <= cfg_wdata[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic accept;
  logic busy;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [EXT_W-1:0]  in_addr_ext;
  logic [ADDR_W-1:0] in_iaddr;

  assign in_addr_ext = EXT_W'(s_axis_tdata[ADDR_IN_W-1:0]);
  assign in_iaddr    = in_addr_ext[ADDR_W-1:0];

  // last committed write; each stage folds it in once
  store_wr_t         hist;
  logic [ADDR_W-1:0] hist_addr;
  store_wr_t         wr3;
  store_wr_t         wr_commit;

  logic [31:0] rd_bytes;
  logic        rd_cand;

  // stage 1: raw read data
  logic                v1;
  logic [ACTION_W-1:0] act1;
  logic [ADDR_IN_W-1:0] addr1;
  logic [ADDR_W-1:0]   iaddr1;
  logic [LIVE_W-1:0]   live1;

  logic [LIM_W-1:0] limit;
  logic             in_range1;
  logic             fits1;

  assign limit     = (LIM_W'(region_bytes) > DEPTH_LIM) ? DEPTH_LIM : LIM_W'(region_bytes);
  assign in_range1 = LIM_W'(addr1) < limit;
  assign fits1     = (LIM_W'(addr1) + LIM_W'(data_size)) < limit;

  // stage 2
  logic                v2;
  logic [ACTION_W-1:0] act2;
  logic [ADDR_W-1:0]   iaddr2;
  logic [7:0]          live_lo2;
  logic signed [32:0]  live_x2;
  logic [31:0]         snap2;
  logic                cand2;
  logic                in_range2;
  logic                fits2;

  // stage 3
  logic                v3;
  logic [ACTION_W-1:0] act3;
  logic [ADDR_W-1:0]   iaddr3;
  logic [7:0]          live_lo3;
  logic signed [32:0]  live_x3;
  logic [31:0]         snap3;
  logic                cand3;
  logic                in_range3;
  logic                fits3;

  logic [31:0]        snap_f3;
  logic               cand_f3;
  logic signed [32:0] opnd_b;
  logic               pass;
  logic               search3;
  logic               result3;

  mscf_store #(
    .REGION_DEPTH(REGION_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .rd_addr (in_iaddr),
    .rd_bytes(rd_bytes),
    .rd_cand (rd_cand),
    .wr      (wr_commit),
    .wr_addr (iaddr3),
    .busy    (busy)
  );

  always_comb begin
    snap_f3 = fwd_bytes(snap3, iaddr3, hist, hist_addr);
    cand_f3 = fwd_cand(cand3, iaddr3, hist, hist_addr);
    if (act3 == ACT_CMP_SNAP) begin
      opnd_b = ext_word(snap_f3, data_size, signed_mode);
    end else begin
      opnd_b = ext_word(search_value, 2'd3, signed_mode);
    end
    case (compare_op)
      CMP_LT:  pass = live_x3 <  opnd_b;
      CMP_GT:  pass = live_x3 >  opnd_b;
      CMP_LE:  pass = live_x3 <= opnd_b;
      CMP_GE:  pass = live_x3 >= opnd_b;
      CMP_EQ:  pass = live_x3 == opnd_b;
      default: pass = live_x3 != opnd_b;
    endcase
    search3 = (act3 == ACT_CMP_SNAP || act3 == ACT_CMP_VALUE) && fits3 && cand_f3;

    wr3.snap_data = live_lo3;
    wr3.snap_we   = v3 && in_range3 &&
                    (act3 == ACT_SNAPSHOT || (search3 && pass && update_snapshot));
    wr3.cand_we   = v3 && in_range3 && (act3 == ACT_SNAPSHOT || (search3 && !pass));
    if (act3 == ACT_SNAPSHOT) begin
      wr3.cand_val = 1'b1;
    end else if (search3 && !pass) begin
      wr3.cand_val = 1'b0;
    end else begin
      wr3.cand_val = cand_f3;
    end
    result3 = in_range3 && wr3.cand_val;

    wr_commit         = wr3;
    wr_commit.snap_we = wr3.snap_we && adv;
    wr_commit.cand_we = wr3.cand_we && adv;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      hist          <= '0;
    end else if (adv) begin
      v1            <= accept;
      v2            <= v1;
      v3            <= v2;
      m_axis_tvalid <= v3;
      hist          <= wr3;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      act1   <= s_axis_tuser;
      addr1  <= s_axis_tdata[ADDR_IN_W-1:0];
      iaddr1 <= in_iaddr;
      live1  <= s_axis_tdata[ADDR_IN_W +: LIVE_W];

      act2      <= act1;
      iaddr2    <= iaddr1;
      live_lo2  <= live1[7:0];
      live_x2   <= ext_word(live1, data_size, signed_mode);
      snap2     <= fwd_bytes(rd_bytes, iaddr1, hist, hist_addr);
      cand2     <= fwd_cand(rd_cand, iaddr1, hist, hist_addr);
      in_range2 <= in_range1;
      fits2     <= fits1;

      act3      <= act2;
      iaddr3    <= iaddr2;
      live_lo3  <= live_lo2;
      live_x3   <= live_x2;
      snap3     <= fwd_bytes(snap2, iaddr2, hist, hist_addr);
      cand3     <= fwd_cand(cand2, iaddr2, hist, hist_addr);
      in_range3 <= in_range2;
      fits3     <= fits2;

      hist_addr    <= iaddr3;
      m_axis_tdata <= {(OUT_TDATA_W - 1)'(0), result3};
    end
  end

  `MSCF_ASSERT_IMP(a_clear_idle, busy, !(v1 || v2 || v3 || m_axis_tvalid), "word in flight during candidate clear")
  `MSCF_ASSERT_IMP(a_commit_not_busy, wr_commit.cand_we || wr_commit.snap_we, !busy && v3, "store write without a live word")
  `MSCF_ASSERT_IMP(a_snap_keeps_cand, wr_commit.snap_we, wr_commit.cand_val, "snapshot written for a dropped candidate")
  `MSCF_ASSERT_NXT(a_hist_frozen, !adv, $stable(hist) && $stable(hist_addr), "forward record moved during stall")

endmodule

`default_nettype wire
